[hw/rtl/sha256_block_compress_unit_defines.svh]
// assertion helpers for the sha-256 compression unit
`ifndef SHA256_BLOCK_COMPRESS_UNIT_DEFINES_SVH
`define SHA256_BLOCK_COMPRESS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every rising edge outside reset
`define S256C_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every rising edge, reset included
`define S256C_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S256C_ASSERT(lbl, prop, msg)
`define S256C_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/s256c_pkg.sv]
`timescale 1ns / 1ps

package s256c_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_CHAIN  = 8;
    localparam int unsigned WINDOW     = 16;
    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned TDATA_W    = 40;

    localparam logic REQ_CHAIN = 1'b0;
    localparam logic REQ_MSG   = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        round_k = k;
    endfunction

endpackage

[hw/rtl/sha256_block_compress_unit.sv]
`timescale 1ns / 1ps
// sha-256 compression, one round per cycle on a single shared round datapath
// chaining loads and the first fifteen message words are accepted in the load state
// after the sixteenth message word: the rounds, the chaining add, then eight
// result words at up to one per cycle as m_axis_tready allows; one 512-bit block per pass
// input is not ready from the sixteenth message word until the last result is taken
// reset (rst_n low, asynchronous) clears chaining value, counters and state

`include "sha256_block_compress_unit_defines.svh"

module sha256_block_compress_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // word_index[2:0], data_word[34:3], zero fill [39:35]
    input  logic [s256c_pkg::TDATA_W-1:0] s_axis_tdata,
    // req_type[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // digest_word[31:0], digest_index[34:32], zero fill [39:35]
    output logic [s256c_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);

    import s256c_pkg::*;

    state_t      state_reg, state_next;
    word_t       chain_reg [NUM_CHAIN];
    word_t       chain_next [NUM_CHAIN];
    word_t       var_reg [NUM_CHAIN];
    word_t       var_next [NUM_CHAIN];
    word_t       win_reg [WINDOW];
    word_t       win_next [WINDOW];
    logic [3:0]  words_cnt_reg, words_cnt_next;
    logic [5:0]  round_cnt_reg, round_cnt_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    logic        s_accept;
    logic        m_accept;
    logic        msg_accept;
    logic        chain_accept;
    logic        last_msg;
    logic [2:0]  in_index;
    word_t       in_word;

    word_t       w_new;
    word_t       t1;
    word_t       t2;
    word_t       ch;
    word_t       maj;

    assign in_index     = s_axis_tdata[2:0];
    assign in_word      = s_axis_tdata[34:3];
    assign s_accept     = s_axis_tvalid && s_axis_tready;
    assign m_accept     = m_axis_tvalid && m_axis_tready;
    assign msg_accept   = s_accept && (s_axis_tuser == REQ_MSG);
    assign chain_accept = s_accept && (s_axis_tuser == REQ_CHAIN);
    assign last_msg     = msg_accept && (words_cnt_reg == 4'd15);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (last_msg)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_cnt_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_accept && (out_idx_reg == 3'd7))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_axis_tready = 1'b1;
            end
            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

    assign m_axis_tdata = {5'b0, out_idx_reg, chain_reg[out_idx_reg]};
    assign m_axis_tlast = (out_idx_reg == 3'd7);

    // shared round datapath
    always_comb
    begin
        w_new = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9]
              + small_sigma1(win_reg[14]);
        ch    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        maj   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]);
        t1    = var_reg[7] + big_sigma1(var_reg[4]) + ch + round_k(round_cnt_reg)
              + win_reg[0];
        t2    = big_sigma0(var_reg[0]) + maj;
    end

    always_comb
    begin
        chain_next     = chain_reg;
        var_next       = var_reg;
        win_next       = win_reg;
        words_cnt_next = words_cnt_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;

        if (chain_accept)
        begin
            chain_next[in_index] = in_word;
        end

        // the window is a shift line: oldest word at slot 0, newest at slot 15
        if (msg_accept)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WINDOW-1] = in_word;
            words_cnt_next     = words_cnt_reg + 4'd1;
        end

        if (last_msg)
        begin
            var_next = chain_reg;
        end

        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WINDOW-1] = w_new;
            var_next[7]    = var_reg[6];
            var_next[6]    = var_reg[5];
            var_next[5]    = var_reg[4];
            var_next[4]    = var_reg[3] + t1;
            var_next[3]    = var_reg[2];
            var_next[2]    = var_reg[1];
            var_next[1]    = var_reg[0];
            var_next[0]    = t1 + t2;
            round_cnt_next = round_cnt_reg + 6'd1;
        end

        if (state_reg == ST_ADD)
        begin
            for (int i = 0; i < NUM_CHAIN; i++)
            begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
            out_idx_next = 3'd0;
        end

        if (m_accept)
        begin
            out_idx_next = out_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            words_cnt_reg <= 4'd0;
            round_cnt_reg <= 6'd0;
            out_idx_reg   <= 3'd0;
            for (int i = 0; i < NUM_CHAIN; i++)
            begin
                chain_reg[i] <= '0;
                var_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            words_cnt_reg <= words_cnt_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            chain_reg     <= chain_next;
            var_reg       <= var_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    `S256C_ASSERT_ALWAYS(a_no_ready_while_output, !(s_axis_tready && m_axis_tvalid), "input ready while results pending")
    `S256C_ASSERT(a_start_rounds, last_msg |=> (state_reg == ST_ROUND), "sixteenth word did not start rounds")
    `S256C_ASSERT(a_round_cnt_idle, (state_reg != ST_ROUND) |-> (round_cnt_reg == 6'd0), "round counter not cleared outside rounds")
    `S256C_ASSERT(a_ready_after_last, (m_accept && m_axis_tlast) |=> s_axis_tready, "not ready after last result")
    `S256C_ASSERT(a_words_clear_on_out, m_axis_tvalid |-> (words_cnt_reg == 4'd0), "message count not cleared during output")

endmodule
